>>> rtl/fvwt_pkg.sv
// shared types, constants and state codes of the fork vote window tracker
package fvwt_pkg;

	// ring of recent votes
	localparam int WINDOW_MAX = 16384;
	localparam int RING_AW    = $clog2(WINDOW_MAX);
	localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
	localparam int TALLY_W    = FILL_W;

	// field widths
	localparam int VER_W   = 8;
	localparam int PCT_W   = 7;
	localparam int HGT_W   = 48;
	localparam int WIN_W   = 15;
	localparam int FIDX_W  = 3;
	localparam int TALLY_DEPTH = 2 ** VER_W;

	// fork table
	localparam int MAX_FORKS = 4;
	localparam int FORK_IW   = (MAX_FORKS > 1) ? $clog2(MAX_FORKS) : 1;
	localparam int SUM_W     = TALLY_W + FORK_IW;
	localparam int PROD_W    = FILL_W + PCT_W;
	localparam int CMP_W     = SUM_W + 7;

	// stream and config widths
	localparam int IN_W       = 64;
	localparam int OUT_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 63;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIG      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NFORK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FORK0     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FORK_LAST = CFG_IDX_W'(3 + MAX_FORKS - 1);

	// reset values of the registers
	localparam logic [WIN_W-1:0] WINDOW_RST = 15'd10080;
	localparam logic [VER_W-1:0] ORIG_RST   = 8'd1;

	typedef struct packed {
		logic [VER_W-1:0] ver;
		logic [PCT_W-1:0] pct;
		logic [HGT_W-1:0] height;
	} fork_t;

	// effective configuration seen by the sequencer
	typedef struct packed {
		logic [FILL_W-1:0]            win;
		logic [VER_W-1:0]             orig;
		logic [FIDX_W-1:0]            nfork;
		fork_t [MAX_FORKS-1:0]        forks;
	} cfg_t;

	typedef struct packed {
		logic               rd;
		logic [RING_AW-1:0] rd_addr;
		logic               wr;
		logic [RING_AW-1:0] wr_addr;
		logic [VER_W-1:0]   wr_data;
	} ring_req_t;

	typedef struct packed {
		logic               rd;
		logic [VER_W-1:0]   rd_addr;
		logic               wr;
		logic [VER_W-1:0]   wr_addr;
		logic [TALLY_W-1:0] wr_data;
	} tally_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EV_CHK,
		ST_EV_TALLY,
		ST_EV_WB,
		ST_PUT,
		ST_INC,
		ST_SC_RD,
		ST_SC_CMP,
		ST_DONE
	} state_t;

endpackage

>>> rtl/fvwt_cfg.sv
// configuration registers and their effective values
module fvwt_cfg import fvwt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [WIN_W-1:0]      win_q;
	logic [VER_W-1:0]      orig_q;
	logic [FIDX_W-1:0]     nfork_q;
	fork_t [MAX_FORKS-1:0] forks_q;
	logic [CFG_IDX_W-1:0]  fsel;

	assign cfg_ready = 1'b1;
	assign fsel      = cfg_index - CFG_FORK0;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= WINDOW_RST;
			orig_q  <= ORIG_RST;
			nfork_q <= '0;
			forks_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index) inside
				CFG_WINDOW: win_q <= cfg_data[WIN_W-1:0];
				CFG_ORIG:   orig_q <= cfg_data[VER_W-1:0];
				CFG_NFORK:  nfork_q <= cfg_data[FIDX_W-1:0];
				[CFG_FORK0:CFG_FORK_LAST]: forks_q[fsel[FORK_IW-1:0]] <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp window and fork count to what the hardware holds
	always_comb begin
		cfg.orig  = orig_q;
		cfg.forks = forks_q;
		if (win_q == '0)
			cfg.win = FILL_W'(1);
		else if (FILL_W'(win_q) > FILL_W'(WINDOW_MAX))
			cfg.win = FILL_W'(WINDOW_MAX);
		else
			cfg.win = FILL_W'(win_q);
		cfg.nfork = (nfork_q > FIDX_W'(MAX_FORKS)) ? FIDX_W'(MAX_FORKS) : nfork_q;
	end

endmodule

>>> rtl/fvwt_ring.sv
// vote ring memory, one write and one registered read per cycle
module fvwt_ring import fvwt_pkg::*; (
	input  logic             clk,
	input  ring_req_t        req,
	output logic [VER_W-1:0] rd_data
);

	logic [VER_W-1:0] mem [WINDOW_MAX];

	// synchronous write and read
	always_ff @(posedge clk) begin
		if (req.wr)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd)
			rd_data <= mem[req.rd_addr];
	end

endmodule

>>> rtl/fvwt_tally.sv
// per-vote tally memory with valid bits so that reset reads as zero
module fvwt_tally import fvwt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tally_req_t         req,
	output logic [TALLY_W-1:0] rd_data
);

	logic [TALLY_W-1:0]     mem [TALLY_DEPTH];
	logic [TALLY_DEPTH-1:0] vld_q;
	logic                   rd_vld_q;
	logic [TALLY_W-1:0]     rd_raw_q;

	// storage
	always_ff @(posedge clk) begin
		if (req.wr)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd)
			rd_raw_q <= mem[req.rd_addr];
	end

	// entry valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr)
				vld_q[req.wr_addr] <= 1'b1;
			if (req.rd)
				rd_vld_q <= vld_q[req.rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

>>> rtl/fvwt_ctrl.sv
// sequencer: version check, eviction, vote entry and fork scan
module fvwt_ctrl import fvwt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,
	output ring_req_t          ring_req,
	input  logic [VER_W-1:0]   ring_rd,
	output tally_req_t         tally_req,
	input  logic [TALLY_W-1:0] tally_rd
);

	function automatic logic [VER_W-1:0] fork_ver(cfg_t c, logic [FIDX_W-1:0] k);
		logic [FIDX_W-1:0] km1;
		km1 = k - FIDX_W'(1);
		return (k == '0) ? c.orig : c.forks[km1[FORK_IW-1:0]].ver;
	endfunction

	state_t              state_q, state_d;
	logic [RING_AW-1:0]  head_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FIDX_W-1:0]   active_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic [VER_W-1:0]    vote_q;
	logic [HGT_W:0]      tgt_q;
	logic                acc_q;
	logic [VER_W-1:0]    rec_q;
	logic [VER_W-1:0]    vic_q;
	logic [FIDX_W-1:0]   n_q;
	logic [SUM_W-1:0]    sum_q;
	logic [PROD_W-1:0]   prod_q;

	logic [FIDX_W-1:0]   active_use;
	logic [VER_W-1:0]    cur_ver;
	logic [VER_W-1:0]    in_bver;
	logic [VER_W-1:0]    in_vote;
	logic [HGT_W-1:0]    in_h;
	logic                in_ok;
	logic [FILL_W-1:0]   old_full;
	logic [FIDX_W-1:0]   nm1;
	fork_t               sel_fork;
	logic [SUM_W-1:0]    sum_new;
	logic [CMP_W-1:0]    sum_x100;
	logic                hit;
	logic                out_free;

	// input word fields
	assign in_bver = s_tdata[VER_W-1:0];
	assign in_vote = s_tdata[2*VER_W-1:VER_W];
	assign in_h    = s_tdata[2*VER_W+HGT_W-1:2*VER_W];

	// current fork, pulled down to a lowered fork count
	assign active_use = (active_q > cfg.nfork) ? cfg.nfork : active_q;
	assign cur_ver    = fork_ver(cfg, active_use);
	assign in_ok      = (in_bver == cur_ver) && (in_vote >= cur_ver);

	// oldest ring slot
	always_comb begin
		if (FILL_W'(head_q) >= fill_q)
			old_full = FILL_W'(head_q) - fill_q;
		else
			old_full = FILL_W'(head_q) + FILL_W'(WINDOW_MAX) - fill_q;
	end

	// fork under scan and its threshold test: 100*sum >= win*pct
	assign nm1      = n_q - FIDX_W'(1);
	assign sel_fork = cfg.forks[nm1[FORK_IW-1:0]];
	assign sum_new  = sum_q + SUM_W'(tally_rd);
	assign sum_x100 = CMP_W'(sum_new) * CMP_W'(100);
	assign hit      = (tgt_q >= {1'b0, sel_fork.height}) && (sum_x100 >= CMP_W'(prod_q));
	assign out_free = !m_tvalid_q || m_tready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and memory requests
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ring_req  = '0;
		tally_req = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = in_ok ? ST_EV_CHK : ST_DONE;
			end
			ST_EV_CHK: begin
				if (fill_q >= cfg.win) begin
					ring_req.rd      = 1'b1;
					ring_req.rd_addr = old_full[RING_AW-1:0];
					state_d          = ST_EV_TALLY;
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_EV_TALLY: begin
				tally_req.rd      = 1'b1;
				tally_req.rd_addr = ring_rd;
				state_d           = ST_EV_WB;
			end
			ST_EV_WB: begin
				tally_req.wr      = 1'b1;
				tally_req.wr_addr = vic_q;
				tally_req.wr_data = tally_rd - TALLY_W'(tally_rd != '0);
				state_d           = ST_EV_CHK;
			end
			ST_PUT: begin
				ring_req.wr       = 1'b1;
				ring_req.wr_addr  = head_q;
				ring_req.wr_data  = vote_q;
				tally_req.rd      = 1'b1;
				tally_req.rd_addr = vote_q;
				state_d           = ST_INC;
			end
			ST_INC: begin
				tally_req.wr      = 1'b1;
				tally_req.wr_addr = vote_q;
				tally_req.wr_data = tally_rd + TALLY_W'(1);
				state_d           = (cfg.nfork > active_use) ? ST_SC_RD : ST_DONE;
			end
			ST_SC_RD: begin
				tally_req.rd      = 1'b1;
				tally_req.rd_addr = sel_fork.ver;
				state_d           = ST_SC_CMP;
			end
			ST_SC_CMP: begin
				if (hit || !(nm1 > active_use))
					state_d = ST_DONE;
				else
					state_d = ST_SC_RD;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ring pointers, current fork and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			fill_q     <= '0;
			active_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_SC_CMP && hit)
				active_q <= n_q;
			else
				active_q <= active_use;
			if (state_q == ST_EV_WB)
				fill_q <= fill_q - FILL_W'(1);
			if (state_q == ST_PUT) begin
				fill_q <= fill_q + FILL_W'(1);
				head_q <= (head_q == RING_AW'(WINDOW_MAX - 1)) ? '0 : head_q + RING_AW'(1);
			end
			if (state_q == ST_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// working registers of the item in flight
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					vote_q <= in_vote;
					tgt_q  <= {1'b0, in_h} + (HGT_W + 1)'(1);
					acc_q  <= in_ok;
					rec_q  <= in_ok ? cur_ver : '0;
				end
			end
			ST_EV_TALLY: vic_q <= ring_rd;
			ST_INC: begin
				n_q   <= cfg.nfork;
				sum_q <= '0;
			end
			ST_SC_RD: prod_q <= PROD_W'(cfg.win) * PROD_W'(sel_fork.pct);
			ST_SC_CMP: begin
				sum_q <= sum_new;
				n_q   <= nm1;
			end
			ST_DONE: begin
				if (out_free)
					m_tdata_q <= OUT_W'({active_use, fork_ver(cfg, active_use), rec_q, acc_q});
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/fork_vote_window_tracker.sv
// top level of the fork vote window tracker: config registers, vote ring, tallies, sequencer
// Sequence: a rejected block goes straight to its result word; an accepted one first evicts
// the oldest votes while the window is full, then writes its vote, raises its tally and scans
// the forks above the current one from the top. One block is in flight at a time, and a
// stalled result word holds the sequencer and so the input.
// Reset: clears pointers, fill count, current fork, output valid and tally valid bits at once.
module fork_vote_window_tracker import fvwt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // block_version, voting_version, block_height
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // accepted, recorded_version, current_version,
	                                         // fork_position, zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t               cfg;
	ring_req_t          ring_req;
	tally_req_t         tally_req;
	logic [VER_W-1:0]   ring_rd;
	logic [TALLY_W-1:0] tally_rd;

	// configuration registers
	fvwt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// vote ring
	fvwt_ring u_ring (
		.clk     (clk),
		.req     (ring_req),
		.rd_data (ring_rd)
	);

	// vote tallies
	fvwt_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tally_req),
		.rd_data (tally_rd)
	);

	// sequencer
	fvwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.ring_req  (ring_req),
		.ring_rd   (ring_rd),
		.tally_req (tally_req),
		.tally_rd  (tally_rd)
	);

endmodule

>>> rtl/fvwt_chk.sv
// port-level checks of the fork vote window tracker and their binding
module fvwt_chk import fvwt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// one block at a time: input closes right after a word is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// fork position stays within the fork table
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:17] <= FIDX_W'(MAX_FORKS)))
		else $error("fork position out of range");

	// a rejected block records no version
	a_rej_rec: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[8:1] == '0))
		else $error("rejected block carries a recorded version");

endmodule

bind fork_vote_window_tracker fvwt_chk u_fvwt_chk (.*);

>>> sim/fork_vote_window_tracker_tb.sv
// self-checking testbench for the fork vote window tracker
`timescale 1ns / 1ps

// tracks the vote window and fork index, and checks the result words against it
class fork_vote_scoreboard;
	typedef struct packed {
		logic [3:0] pad;
		logic [2:0] pos;
		logic [7:0] cur;
		logic [7:0] rec;
		logic       acc;
	} outcome_t;

	bit [14:0]        window_reg;
	bit [7:0]         orig_reg;
	bit [2:0]         count_reg;
	fvwt_pkg::fork_t  fork_tab [4];
	bit [7:0]         vote_hist [fvwt_pkg::WINDOW_MAX];
	int unsigned      tally [256];
	int unsigned      head;
	int unsigned      fill;
	int unsigned      active;
	outcome_t         outcomes [$];
	int               errors;

	function new();
		window_reg = fvwt_pkg::WINDOW_RST;
		orig_reg   = fvwt_pkg::ORIG_RST;
		count_reg  = '0;
		foreach (fork_tab[k]) fork_tab[k] = '0;
		foreach (tally[v]) tally[v] = 0;
		head   = 0;
		fill   = 0;
		active = 0;
		errors = 0;
	endfunction

	task report(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// window of 0 counts as 1, oversize clamps to the ring depth
	function int unsigned eff_window();
		if (window_reg == 0) return 1;
		if (window_reg > fvwt_pkg::WINDOW_MAX) return fvwt_pkg::WINDOW_MAX;
		return window_reg;
	endfunction

	function int unsigned eff_count();
		return (count_reg > fvwt_pkg::MAX_FORKS) ? fvwt_pkg::MAX_FORKS : count_reg;
	endfunction

	function bit [7:0] fork_ver(int unsigned k);
		return (k == 0) ? orig_reg : fork_tab[k-1].ver;
	endfunction

	function bit [6:0] fork_pct(int unsigned k);
		return (k == 0) ? 7'd0 : fork_tab[k-1].pct;
	endfunction

	function bit [47:0] fork_height(int unsigned k);
		return (k == 0) ? 48'd0 : fork_tab[k-1].height;
	endfunction

	function bit [7:0] cur_version();
		return fork_ver(active);
	endfunction

	// register write; lowering the fork count pulls the current fork down
	function void write_reg(bit [2:0] idx, bit [62:0] data);
		case (idx)
			fvwt_pkg::CFG_WINDOW: window_reg = data[14:0];
			fvwt_pkg::CFG_ORIG:   orig_reg = data[7:0];
			fvwt_pkg::CFG_NFORK: begin
				count_reg = data[2:0];
				if (active > eff_count()) active = eff_count();
			end
			default: begin
				if (idx inside {[fvwt_pkg::CFG_FORK0:fvwt_pkg::CFG_FORK_LAST]})
					fork_tab[idx - fvwt_pkg::CFG_FORK0] = fvwt_pkg::fork_t'(data);
			end
		endcase
	endfunction

	// one accepted block: window update, fork scan, queued result word
	function void note_block(bit [7:0] bver, bit [7:0] vote, bit [47:0] h);
		outcome_t          o;
		bit [7:0]          cur;
		int unsigned       win;
		int unsigned       n;
		int unsigned       slot;
		longint unsigned   sum;
		longint unsigned   thr;
		longint unsigned   target;
		cur = cur_version();
		win = eff_window();
		o   = '0;
		if (bver == cur && vote >= cur) begin
			o.acc = 1'b1;
			o.rec = cur;
			// oldest votes leave until there is room
			while (fill >= win) begin
				slot = (head + fvwt_pkg::WINDOW_MAX - fill) % fvwt_pkg::WINDOW_MAX;
				if (tally[vote_hist[slot]] > 0) tally[vote_hist[slot]]--;
				fill--;
			end
			vote_hist[head] = vote;
			head = (head + 1) % fvwt_pkg::WINDOW_MAX;
			fill++;
			tally[vote]++;
			// scan the forks above the current one from the top
			target = h;
			target = target + 1;
			sum = 0;
			for (n = eff_count(); n > active; n--) begin
				thr = (64'(win) * 64'(fork_pct(n)) + 64'd99) / 64'd100;
				sum += tally[fork_ver(n)];
				if (target >= fork_height(n) && sum >= thr) begin
					active = n;
					break;
				end
			end
		end
		o.cur = cur_version();
		o.pos = active[2:0];
		outcomes = {outcomes, o};
	endfunction

	task check_word(bit [23:0] word);
		outcome_t got;
		outcome_t want;
		got = word;
		if (outcomes.size() == 0) begin
			report($sformatf("result word %h with nothing expected", word));
			return;
		end
		want = outcomes[0];
		outcomes.delete(0);
		if (got.acc != want.acc || got.rec != want.rec || got.cur != want.cur ||
		    got.pos != want.pos)
			report($sformatf("got acc %0d rec %0d cur %0d pos %0d, want %0d %0d %0d %0d",
			                 got.acc, got.rec, got.cur, got.pos,
			                 want.acc, want.rec, want.cur, want.pos));
	endtask
endclass

module fork_vote_window_tracker_tb import fvwt_pkg::*; ();
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam logic [47:0]           HMAX       = '1;
	localparam longint                LIMIT_NS   = 30_000_000;

	typedef struct packed {
		logic [47:0] height;
		logic [7:0]  vote;
		logic [7:0]  ver;
	} block_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;     // block_version, voting_version, block_height
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;          // accepted, recorded_version, current_version,
	                                         // fork_position, zero pad
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fork_vote_scoreboard sb;
	int          send_idle_pct = 15;
	int          recv_idle_pct = 78;
	int          words_seen = 0;
	logic        hold_off = 1'b0;
	int unsigned ver_base;
	int unsigned random_sent;
	int unsigned batch;
	block_t      blk;

	fork_vote_window_tracker dut (.*);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// result side: check words and random stalls
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_word(m_tdata);
			words_seen++;
		end
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// one long hold-off of the receiver while the sender keeps offering
	initial begin
		wait (words_seen >= 1000);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	// guard against a hang
	initial begin
		#(LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [62:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic send_block(input logic [7:0] bver, input logic [7:0] vote,
	                          input logic [47:0] h);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {h, vote, bver};
		do @(posedge clk); while (!s_tready);
		sb.note_block(bver, vote, h);
	endtask

	// stop offering and wait until every result word is back
	task automatic drain();
		s_tvalid  <= 1'b0;
		cfg_valid <= 1'b0;
		do @(posedge clk); while (sb.outcomes.size() != 0);
	endtask

	function automatic fork_t make_fork(logic [7:0] ver, logic [6:0] pct, logic [47:0] h);
		fork_t f;
		f.ver    = ver;
		f.pct    = pct;
		f.height = h;
		return f;
	endfunction

	function automatic logic [7:0] pool_ver();
		return 8'(ver_base + $urandom_range(0, 4));
	endfunction

	function automatic fork_t random_fork();
		fork_t       f;
		int unsigned r;
		if ($urandom_range(0, 19) == 0) return fork_t'(63'({$urandom, $urandom}));
		f.ver = ($urandom_range(0, 19) == 0) ? 8'($urandom) : pool_ver();
		r = $urandom_range(0, 99);
		if (r < 10)      f.pct = 7'd0;
		else if (r < 20) f.pct = 7'd100;
		else if (r < 30) f.pct = 7'($urandom_range(101, 127));
		else             f.pct = 7'($urandom_range(0, 100));
		r = $urandom_range(0, 99);
		if (r < 15)      f.height = '0;
		else if (r < 25) f.height = HMAX;
		else if (r < 40) f.height = 48'({$urandom, $urandom});
		else             f.height = 48'($urandom_range(0, 80));
		return f;
	endfunction

	// heights cluster around the activation heights
	function automatic logic [47:0] pick_height();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return sb.fork_height($urandom_range(1, MAX_FORKS)) - 48'($urandom_range(0, 2));
		if (r < 60) return 48'($urandom_range(0, 63));
		if (r < 70) return HMAX;
		if (r < 75) return '0;
		return 48'({$urandom, $urandom});
	endfunction

	// mostly blocks that pass the version check, voting for higher forks
	function automatic block_t pick_block();
		block_t      b;
		logic [7:0]  cur;
		int unsigned r;
		cur      = sb.cur_version();
		b.ver    = cur;
		b.height = pick_height();
		r = $urandom_range(0, 99);
		if (r < 10) begin
			b = block_t'({$urandom, $urandom});
		end else if (r < 18) begin
			b.vote = (cur == 0) ? 8'($urandom) : 8'($urandom_range(0, cur - 1));
			if (r < 12) b.ver = 8'($urandom);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				b.vote = sb.fork_ver($urandom_range(1, MAX_FORKS));
				if (b.vote < cur) b.vote = cur;
			end else if (r < 75) begin
				b.vote = cur;
			end else begin
				b.vote = 8'($urandom_range(cur, 255));
			end
		end
		return b;
	endfunction

	// new settings for a batch; only some registers change each time
	task automatic shuffle_config();
		int unsigned r;
		if ($urandom_range(0, 4) == 0) ver_base = $urandom_range(0, 251);
		if ($urandom_range(0, 1) == 0) begin
			r = $urandom_range(0, 99);
			if (r < 55)      cfg_write(CFG_WINDOW, 63'($urandom_range(1, 12)));
			else if (r < 65) cfg_write(CFG_WINDOW, 63'd0);
			else if (r < 75) cfg_write(CFG_WINDOW, 63'(WINDOW_MAX));
			else if (r < 80) cfg_write(CFG_WINDOW, 63'h7FFF);
			else if (r < 85) cfg_write(CFG_WINDOW, 63'($urandom_range(16385, 32767)));
			else             cfg_write(CFG_WINDOW, 63'($urandom_range(13, 300)));
		end
		if ($urandom_range(0, 99) < 30) cfg_write(CFG_ORIG, 63'(pool_ver()));
		if ($urandom_range(0, 99) < 60) cfg_write(CFG_NFORK, 63'($urandom_range(0, 7)));
		for (int k = 0; k < MAX_FORKS; k++)
			if ($urandom_range(0, 99) < 40) cfg_write(CFG_FORK0 + 3'(k), random_fork());
		if ($urandom_range(0, 19) == 0) cfg_write(CFG_UNUSED, 63'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		ver_base = $urandom_range(0, 251);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: only the original fork, field extremes
		send_block(8'd1, 8'd1, '0);
		send_block(8'd1, 8'd0, 48'd5);
		send_block(8'd0, 8'd255, HMAX);
		send_block(8'd255, 8'd255, HMAX);
		send_block(8'd1, 8'd255, HMAX);
		drain();

		// small window, four forks, one never reachable, one out of order
		cfg_write(CFG_WINDOW, 63'd3);
		cfg_write(CFG_ORIG, 63'd1);
		cfg_write(CFG_FORK0,         make_fork(8'd2, 7'd100, 48'd5));
		cfg_write(CFG_FORK0 + 3'd1, make_fork(8'd4, 7'd67, '0));
		cfg_write(CFG_FORK0 + 3'd2, make_fork(8'd255, 7'd127, '0));
		cfg_write(CFG_FORK0 + 3'd3, make_fork(8'd0, 7'd0, HMAX));
		cfg_write(CFG_NFORK, 63'd7);
		cfg_write(CFG_UNUSED, '1);
		cfg_valid <= 1'b0;
		send_block(8'd1, 8'd2, '0);
		send_block(8'd1, 8'd2, 48'd3);
		send_block(8'd1, 8'd2, 48'd4);
		send_block(8'd1, 8'd4, 48'd9);
		send_block(8'd2, 8'd1, 48'd9);
		send_block(8'd2, 8'd4, 48'd10);
		send_block(8'd2, 8'd4, 48'd11);
		send_block(8'd2, 8'd4, 48'd12);
		send_block(8'd4, 8'd255, HMAX - 1);
		send_block(8'd0, 8'd0, '0);
		drain();

		// fork count lowered below the current fork, then the window shrunk to one
		cfg_write(CFG_NFORK, 63'd2);
		cfg_write(CFG_WINDOW, 63'd0);
		cfg_valid <= 1'b0;
		send_block(8'd4, 8'd4, '0);
		drain();

		// oversize window, top original version
		cfg_write(CFG_WINDOW, 63'h7FFF);
		cfg_write(CFG_ORIG, 63'd255);
		cfg_write(CFG_NFORK, 63'd0);
		cfg_valid <= 1'b0;
		send_block(8'd255, 8'd255, 48'd7);
		send_block(8'd255, 8'd254, '0);

		// random batches, each under fresh settings
		random_sent = 0;
		while (random_sent < 1350) begin
			drain();
			if (random_sent < 450) begin
				send_idle_pct = 15;
				recv_idle_pct = 78;
			end else if (random_sent < 900) begin
				send_idle_pct = 78;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			shuffle_config();
			batch = $urandom_range(30, 45);
			repeat (batch) begin
				blk = pick_block();
				send_block(blk.ver, blk.vote, blk.height);
			end
			random_sent += batch;
		end
		drain();
		repeat (20) @(posedge clk);

		if (sb.outcomes.size() != 0)
			sb.report($sformatf("%0d result words never arrived", sb.outcomes.size()));
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
